FILE: design/button_press_classifier_macros.svh
// assertion macros used by the button press classifier port checker
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// property checked at every clock edge outside reset
`define BPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("button press classifier check failed");

// property checked at every clock edge, reset included
`define BPC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("button press classifier reset check failed");

`endif

FILE: design/bpc_pkg.sv
// shared types and constants of the button press classifier
package bpc_pkg;

   // configuration field widths
   localparam int DEBOUNCE_W  = 16;
   localparam int THRESH_W    = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int RSP_DATA_W  = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_MAX     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_MIN      = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERY_LONG_MIN = 8'd3;

   // configuration reset values
   localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE      = 16'd30;
   localparam logic [THRESH_W-1:0]   RST_SHORT_MAX     = 32'd1000;
   localparam logic [THRESH_W-1:0]   RST_LONG_MIN      = 32'd2000;
   localparam logic [THRESH_W-1:0]   RST_VERY_LONG_MIN = 32'd5000;

   // classification of a release
   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_SHORT     = 2'd1,
      KIND_LONG      = 2'd2,
      KIND_VERY_LONG = 2'd3
   } press_kind_type;

   // current configuration
   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ms;
      logic [THRESH_W-1:0]   short_max_ms;
      logic [THRESH_W-1:0]   long_min_ms;
      logic [THRESH_W-1:0]   very_long_min_ms;
   } cfg_type;

endpackage

FILE: design/button_press_classifier.sv
// top level of the button press classifier
//
// Requests carry one raw button sample: the level and a millisecond timestamp.
// Every request gives exactly one response holding the press kind: none,
// short, long or very long, the latter three only on a debounced release.
// Configuration writes on the csr channel set the debounce time and the
// three thresholds; csr_ready is always high, writes to unknown indexes are
// dropped, and writes belong only to times when no request is in flight.
// A request passes through one input register, then the debounce and classify
// logic feeding the response register. Throughput is one request per cycle
// while the receiver takes responses, bound by the single state update of
// the debounce logic.
// When the receiver stalls, the response register holds its value and the
// input register fills; req_tready drops only once both are occupied.
// Synchronous reset restores the default configuration, clears the debounce
// state so the next sample only initializes it, and empties both registers.
module button_press_classifier #(
   parameter int TIME_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: [0] level, [TIME_BITS:1] time_ms, rest zero
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((TIME_BITS+1+7)/8)*8-1:0]     req_tdata,
   // response: [1:0] press_kind, rest zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bpc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bpc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]       csr_data
);
   import bpc_pkg::*;

   cfg_type              cfg;
   logic                 in_valid_ff, in_valid_in;
   logic                 in_level_ff;
   logic [TIME_BITS-1:0] in_time_ff;
   logic                 out_valid_ff, out_valid_in;
   press_kind_type       out_kind_ff;
   press_kind_type       step_kind;
   logic                 advance;
   logic                 step;
   logic                 req_accept;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // pipeline control
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_level_ff <= req_tdata[0];
         in_time_ff  <= req_tdata[TIME_BITS:1];
      end
   end

   bpc_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .level (in_level_ff),
      .now   (in_time_ff),
      .cfg   (cfg),
      .kind  (step_kind)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_kind_ff <= step_kind;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_kind_ff);

endmodule

FILE: design/bpc_csr.sv
// configuration registers of the button press classifier
module bpc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]   csr_data,
   output bpc_pkg::cfg_type                 cfg
);
   import bpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE:      cfg_in.debounce_ms      = csr_data[DEBOUNCE_W-1:0];
            CSR_SHORT_MAX:     cfg_in.short_max_ms     = csr_data[THRESH_W-1:0];
            CSR_LONG_MIN:      cfg_in.long_min_ms      = csr_data[THRESH_W-1:0];
            CSR_VERY_LONG_MIN: cfg_in.very_long_min_ms = csr_data[THRESH_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= RST_DEBOUNCE;
         cfg_ff.short_max_ms     <= RST_SHORT_MAX;
         cfg_ff.long_min_ms      <= RST_LONG_MIN;
         cfg_ff.very_long_min_ms <= RST_VERY_LONG_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/bpc_classify.sv
// held time classification against the press thresholds
module bpc_classify #(
   parameter int TIME_BITS = 32
) (
   input  logic [TIME_BITS-1:0]   held,
   input  bpc_pkg::cfg_type       cfg,
   output bpc_pkg::press_kind_type kind
);
   import bpc_pkg::*;

   localparam int CMP_W = (TIME_BITS > THRESH_W) ? TIME_BITS : THRESH_W;

   logic [CMP_W-1:0] held_x;
   logic [CMP_W-1:0] short_x;
   logic [CMP_W-1:0] long_x;
   logic [CMP_W-1:0] very_x;

   // zero extend everything to a common compare width
   assign held_x  = CMP_W'(held);
   assign short_x = CMP_W'(cfg.short_max_ms);
   assign long_x  = CMP_W'(cfg.long_min_ms);
   assign very_x  = CMP_W'(cfg.very_long_min_ms);

   // short wins, then very long, then long, gap gives none
   always_comb begin
      if (held_x < short_x) begin
         kind = KIND_SHORT;
      end else if (held_x >= very_x) begin
         kind = KIND_VERY_LONG;
      end else if (held_x >= long_x) begin
         kind = KIND_LONG;
      end else begin
         kind = KIND_NONE;
      end
   end

endmodule

FILE: design/bpc_core.sv
// debounce state and release detection of the button press classifier
module bpc_core #(
   parameter int TIME_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    level,
   input  logic [TIME_BITS-1:0]    now,
   input  bpc_pkg::cfg_type        cfg,
   output bpc_pkg::press_kind_type kind
);
   import bpc_pkg::*;

   logic                 started_ff, started_in;
   logic                 last_level_ff, last_level_in;
   logic                 steady_level_ff, steady_level_in;
   logic [TIME_BITS-1:0] change_time_ff, change_time_in;
   logic [TIME_BITS-1:0] press_start_ff, press_start_in;
   logic                 skip_release_ff, skip_release_in;

   logic [TIME_BITS-1:0] change_time_new;
   logic [TIME_BITS-1:0] since_change;
   logic [TIME_BITS-1:0] held;
   logic                 settled;
   press_kind_type       class_kind;

   // time of the latest raw change including this sample
   assign change_time_new = (level != last_level_ff) ? now : change_time_ff;
   assign since_change    = now - change_time_new;
   assign settled         = since_change >= TIME_BITS'(cfg.debounce_ms);
   assign held            = change_time_new - press_start_ff;

   bpc_classify #(
      .TIME_BITS (TIME_BITS)
   ) u_classify (
      .held (held),
      .cfg  (cfg),
      .kind (class_kind)
   );

   // next state and result for one sample
   always_comb begin
      started_in      = started_ff;
      last_level_in   = last_level_ff;
      steady_level_in = steady_level_ff;
      change_time_in  = change_time_ff;
      press_start_in  = press_start_ff;
      skip_release_in = skip_release_ff;
      kind            = KIND_NONE;
      if (step) begin
         if (!started_ff) begin
            // first sample only captures the state
            started_in      = 1'b1;
            last_level_in   = level;
            steady_level_in = level;
            change_time_in  = now;
            press_start_in  = now;
            skip_release_in = level;
         end else begin
            last_level_in  = level;
            change_time_in = change_time_new;
            if (level != steady_level_ff && settled) begin
               steady_level_in = level;
               if (level) begin
                  press_start_in = change_time_new;
               end else if (skip_release_ff) begin
                  // release of a press already held at the first sample
                  skip_release_in = 1'b0;
               end else begin
                  kind = class_kind;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff      <= 1'b0;
         last_level_ff   <= 1'b0;
         steady_level_ff <= 1'b0;
         change_time_ff  <= '0;
         press_start_ff  <= '0;
         skip_release_ff <= 1'b0;
      end else begin
         started_ff      <= started_in;
         last_level_ff   <= last_level_in;
         steady_level_ff <= steady_level_in;
         change_time_ff  <= change_time_in;
         press_start_ff  <= press_start_in;
         skip_release_ff <= skip_release_in;
      end
   end

endmodule

FILE: design/bpc_checker.sv
// port level checks of the button press classifier
`include "button_press_classifier_macros.svh"

module bpc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bpc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // stalled response keeps its value
   `BPC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // reset empties the response register
   `BPC_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid)

   // an empty response register never blocks requests
   `BPC_ASSERT(a_no_false_stall, clock, reset, !rsp_tvalid |-> req_tready)

   // request accepted while no response is waiting is followed by a valid response
   `BPC_ASSERT(a_latency, clock, reset, req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/button_press_classifier_checker.sv
// checker that predicts and compares the press kind of every button sample
module button_press_classifier_checker #(
   parameter int REQ_W = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [REQ_W-1:0]                req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [bpc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [bpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              fail_count,
   output int                              pending,
   output int                              checked,
   output int                              releases
);
   import bpc_pkg::*;

   // shadow of the thresholds and of the debounce state
   cfg_type        cfg;
   logic           primed;
   logic           raw_level;
   logic           stable_level;
   logic           ignore_release;
   logic [31:0]    edge_stamp;
   logic [31:0]    hold_start;
   press_kind_type pending_kinds[$];

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      releases   = 0;
   end

   // short test first, then very long, then long; the gap gives none
   function automatic press_kind_type grade_hold(input logic [31:0] held);
      if (held < cfg.short_max_ms) return KIND_SHORT;
      if (held >= cfg.very_long_min_ms) return KIND_VERY_LONG;
      if (held >= cfg.long_min_ms) return KIND_LONG;
      return KIND_NONE;
   endfunction

   // advance the debounce state by one sample
   task automatic predict_sample(input logic lvl, input logic [31:0] stamp,
                                 output press_kind_type kind);
      kind = KIND_NONE;
      if (!primed) begin
         // first sample only captures; a held button is ignored until release
         primed         = 1'b1;
         raw_level      = lvl;
         stable_level   = lvl;
         edge_stamp     = stamp;
         hold_start     = stamp;
         ignore_release = lvl;
      end else begin
         if (lvl != raw_level) begin
            raw_level  = lvl;
            edge_stamp = stamp;
         end
         if (raw_level != stable_level &&
             (stamp - edge_stamp) >= 32'(cfg.debounce_ms)) begin
            stable_level = raw_level;
            if (stable_level) begin
               hold_start = edge_stamp;
            end else if (ignore_release) begin
               ignore_release = 1'b0;
            end else begin
               kind = grade_hold(edge_stamp - hold_start);
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      press_kind_type want;
      press_kind_type kind;
      if (reset) begin
         cfg            = '{RST_DEBOUNCE, RST_SHORT_MAX, RST_LONG_MIN, RST_VERY_LONG_MIN};
         primed         = 1'b0;
         raw_level      = 1'b0;
         stable_level   = 1'b0;
         ignore_release = 1'b0;
         edge_stamp     = '0;
         hold_start     = '0;
         pending_kinds.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE:      cfg.debounce_ms      = csr_data[DEBOUNCE_W-1:0];
               CSR_SHORT_MAX:     cfg.short_max_ms     = csr_data;
               CSR_LONG_MIN:      cfg.long_min_ms      = csr_data;
               CSR_VERY_LONG_MIN: cfg.very_long_min_ms = csr_data;
               default: ;
            endcase
         end
         // compare responses before taking new requests
         if (rsp_tvalid && rsp_tready) begin
            if (pending_kinds.size() == 0) begin
               $error("press_kind response with no request outstanding: got %0d",
                      rsp_tdata[1:0]);
               fail_count++;
            end else begin
               want = pending_kinds.pop_front();
               checked++;
               if (want != KIND_NONE) releases++;
               if (rsp_tdata[1:0] !== want) begin
                  $error("press_kind mismatch: expected %0d, actual %0d",
                         want, rsp_tdata[1:0]);
                  fail_count++;
               end
               if (rsp_tdata[RSP_DATA_W-1:2] !== '0) begin
                  $error("rsp_tdata padding mismatch: expected 0, actual %0h",
                         rsp_tdata[RSP_DATA_W-1:2]);
                  fail_count++;
               end
            end
         end
         // predict each accepted request
         if (req_tvalid && req_tready) begin
            predict_sample(req_tdata[0], req_tdata[32:1], kind);
            pending_kinds.push_back(kind);
         end
      end
      pending = pending_kinds.size();
   end

endmodule

FILE: tb/tb_button_press_classifier.sv
// testbench top: stimulus, idle patterns and verdict for the press classifier
module tb_button_press_classifier;
   import bpc_pkg::*;

   localparam int TIME_BITS    = 32;
   localparam int REQ_W        = ((TIME_BITS + 1 + 7) / 8) * 8;
   localparam int STALL_CYCLES = 300;
   localparam int BLOCK_ITEMS  = 290;
   localparam int DRAIN_LIMIT  = 5000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = CSR_VERY_LONG_MIN + 8'd1;

   // clock, reset and block inputs, all known from time zero
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_ready;

   // idle control
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic long_stall    = 1'b0;
   int   stall_count   = 0;

   // checker results and run bookkeeping
   int          fail_count;
   int          pending;
   int          checked;
   int          releases;
   int          samples_sent  = 0;
   int          settings_used = 1;
   logic [31:0] now;
   cfg_type     cfg_now;

   always #2 clock = ~clock;

   button_press_classifier #(.TIME_BITS(TIME_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [0] level, [32:1] time_ms, rest zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [1:0] press_kind, rest zero
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   button_press_classifier_checker #(.REQ_W(REQ_W)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .releases   (releases)
   );

   // receiver: random backpressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_stall && stall_count < STALL_CYCLES) begin
         rsp_tready  <= 1'b0;
         stall_count <= stall_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   initial begin
      #1600000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // offer one sample; valid stays high into the next request
   task automatic send_sample(input logic lvl, input logic [31:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - 33){1'b0}}, stamp, lvl};
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // stop requests and wait for every press kind to come back
   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] deb, input logic [31:0] smax,
                            input logic [31:0] lmin, input logic [31:0] vmin,
                            input logic poke_unmapped);
      quiesce();
      // upper bits of the debounce write must be dropped
      write_reg(CSR_DEBOUNCE, {16'($urandom), deb});
      write_reg(CSR_SHORT_MAX, smax);
      write_reg(CSR_LONG_MIN, lmin);
      write_reg(CSR_VERY_LONG_MIN, vmin);
      if (poke_unmapped) write_reg(CSR_UNMAPPED, $urandom);
      csr_valid <= 1'b0;
      @(posedge clock);
      cfg_now = '{deb, smax, lmin, vmin};
      settings_used++;
   endtask

   // clean press and release with exact held time
   task automatic tap(input logic [31:0] held);
      send_sample(1'b1, now);
      send_sample(1'b1, now + cfg_now.debounce_ms);
      send_sample(1'b0, now + held);
      send_sample(1'b0, now + held + cfg_now.debounce_ms);
      now = now + held + 32'd100;
   endtask

   // held times around the thresholds, plus wide random ones
   function automatic logic [31:0] pick_hold();
      case ($urandom_range(9))
         0: return cfg_now.short_max_ms - 32'd1;
         1: return cfg_now.short_max_ms;
         2: return cfg_now.long_min_ms - 32'd1;
         3: return cfg_now.long_min_ms;
         4: return cfg_now.very_long_min_ms - 32'd1;
         5: return cfg_now.very_long_min_ms;
         6: return $urandom;
         7: return $urandom_range(cfg_now.short_max_ms);
         default: return $urandom_range(cfg_now.very_long_min_ms, cfg_now.short_max_ms);
      endcase
   endfunction

   // contact chatter shorter than the debounce time, ending at ~lvl
   task automatic chatter(input logic lvl);
      int bounces;
      bounces = ($urandom_range(1) == 0) ? 0 : $urandom_range(3, 1);
      repeat (bounces) begin
         send_sample(lvl, now);
         now = now + $urandom_range(cfg_now.debounce_ms / 2);
         send_sample(~lvl, now);
         now = now + $urandom_range(cfg_now.debounce_ms / 2);
      end
   endtask

   // one press with optional chatter on both edges and samples while held
   task automatic press_cycle();
      logic [31:0] held;
      logic [31:0] t0;
      logic [31:0] off;
      held = pick_hold();
      chatter(1'b1);
      t0 = now;
      send_sample(1'b1, t0);
      if (held > 32'(cfg_now.debounce_ms)) begin
         off = 32'(cfg_now.debounce_ms);
         send_sample(1'b1, t0 + off);
         repeat ($urandom_range(2)) begin
            off = off + $urandom_range((held - off) / 2);
            send_sample(1'b1, t0 + off);
         end
      end
      now = t0 + held;
      chatter(1'b0);
      send_sample(1'b0, now);
      now = now + cfg_now.debounce_ms + $urandom_range(3);
      send_sample(1'b0, now);
      now = now + $urandom_range(2000);
   endtask

   // mostly well-formed presses, some random samples and time jumps
   task automatic random_block(input int count);
      int target;
      target = samples_sent + count;
      while (samples_sent < target) begin
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(3) == 0) now = $urandom;
            send_sample(1'($urandom_range(1)), $urandom);
         end else begin
            press_cycle();
         end
      end
   endtask

   initial begin
      int waited;
      cfg_now       = '{RST_DEBOUNCE, RST_SHORT_MAX, RST_LONG_MIN, RST_VERY_LONG_MIN};
      send_idle_pct = 17;
      recv_idle_pct <= 62;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: held at start, release discarded, all kinds, timestamp wrap
      now = 32'hFFFF_FFF0;
      send_sample(1'b1, now);
      send_sample(1'b1, now + 32'd50);
      now = now + 32'd100;
      send_sample(1'b0, now);
      send_sample(1'b0, now + 32'd30);
      now = now + 32'd200;
      tap(32'd999);
      tap(32'd1000);
      tap(32'd2000);
      tap(32'd5000);
      // bounce too short to count, then a timestamp that steps back
      send_sample(1'b1, now);
      send_sample(1'b0, now + 32'd10);
      now = now + 32'd100;
      send_sample(1'b1, now);
      send_sample(1'b1, now - 32'd5);
      now = now + 32'd200;

      // sender idles lightly, receiver heavily
      random_block(BLOCK_ITEMS);
      configure(16'd0, 32'd0, 32'd0, 32'd0, 1'b0);
      random_block(BLOCK_ITEMS);

      // sender idles heavily, receiver lightly
      send_idle_pct = 62;
      recv_idle_pct <= 17;
      configure(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      random_block(BLOCK_ITEMS);
      configure(16'd20, 32'd3000, 32'd500, 32'd1000, 1'b0);
      random_block(BLOCK_ITEMS);

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      configure(16'($urandom_range(100, 1)), $urandom_range(800, 50),
                $urandom_range(1300, 800), $urandom_range(4000, 1300), 1'b1);
      random_block(BLOCK_ITEMS);
      configure(RST_DEBOUNCE, RST_SHORT_MAX, RST_LONG_MIN, RST_VERY_LONG_MIN, 1'b0);
      // receiver holds off while presses keep coming, so the input backs up
      long_stall <= 1'b1;
      repeat (4) press_cycle();
      long_stall <= 1'b0;
      random_block(BLOCK_ITEMS);

      // drain
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending != 0) $error("press_kind: %0d responses never arrived", pending);

      $display("sent %0d button samples under %0d threshold settings and three idle patterns",
               samples_sent, settings_used);
      $display("compared %0d press kinds, %0d of them classified releases",
               checked, releases);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/bpc_pkg.sv
design/bpc_csr.sv
design/bpc_classify.sv
design/bpc_core.sv
design/button_press_classifier.sv
design/bpc_checker.sv
tb/button_press_classifier_checker.sv
tb/tb_button_press_classifier.sv
